// File: rtl/pet_pkg.sv
// shared types, codes and constants for the ping and echo trip timer
package pet_pkg;

	localparam int NUM_BINS_DEF   = 6;
	localparam int TIME_BITS_DEF  = 32;
	localparam int MAG_BITS_DEF   = 24;

	localparam int MAG_FIELDS     = 6;
	localparam int MAG_FIELD_BITS = 24;
	localparam int BIN_SLOTS      = 8;
	localparam int BIN_IDX_BITS   = 3;
	localparam int FIELD_TIME_BITS = 32;
	localparam int COUNT_BITS     = 16;
	localparam logic [FIELD_TIME_BITS-1:0] MS_TO_US = 32'd1000;

	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_DETECT_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK_WINDOW      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BEEP_LENGTH      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_REPLY_TIMEOUT    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RISING_EDGE      = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GUARD_BEFORE     = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GUARD_AFTER      = 3'd6;

	// command codes
	localparam logic [1:0] FUNC_HEARTBEAT  = 2'd0;
	localparam logic [1:0] FUNC_GO         = 2'd1;
	localparam logic [1:0] FUNC_STOP       = 2'd2;
	localparam logic [1:0] FUNC_CONTINUOUS = 2'd3;

	typedef struct packed {
		logic [1:0]                func;
		logic [31:0]               cmd_arg;
		logic [31:0]               now_us;
		logic                      leak_seen;
		logic [MAG_FIELD_BITS-1:0] mag_bin0;
		logic [MAG_FIELD_BITS-1:0] mag_bin1;
		logic [MAG_FIELD_BITS-1:0] mag_bin2;
		logic [MAG_FIELD_BITS-1:0] mag_bin3;
		logic [MAG_FIELD_BITS-1:0] mag_bin4;
		logic [MAG_FIELD_BITS-1:0] mag_bin5;
	} item_t;

	typedef struct packed {
		logic                    tx_on;
		logic                    relay_rx;
		logic                    sampler_on;
		logic                    high_voltage_on;
		logic                    trip_valid;
		logic                    trip_timed_out;
		logic [31:0]             trip_time_us;
		logic [BIN_IDX_BITS-1:0] detected_bin;
		logic                    detect_event;
		logic                    series_done;
		logic [COUNT_BITS-1:0]   pings_done;
		logic                    leak_alarm;
	} result_t;

	typedef struct packed {
		logic [23:0] detect_threshold;
		logic [31:0] peak_window_us;
		logic [31:0] beep_length_us;
		logic [31:0] reply_timeout_us;
		logic        rising_edge_mode;
		logic [31:0] guard_before_talk_us;
		logic [31:0] guard_after_beep_us;
	} cfg_t;

endpackage

// File: rtl/pet_cfg.sv
// configuration register file
module pet_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pet_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [pet_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output pet_pkg::cfg_t                      cfg
);

	pet_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pet_pkg::CFG_DETECT_THRESHOLD: cfg_q.detect_threshold <= cfg_data[23:0];
				pet_pkg::CFG_PEAK_WINDOW:      cfg_q.peak_window_us <= cfg_data;
				pet_pkg::CFG_BEEP_LENGTH:      cfg_q.beep_length_us <= cfg_data;
				pet_pkg::CFG_REPLY_TIMEOUT:    cfg_q.reply_timeout_us <= cfg_data;
				pet_pkg::CFG_RISING_EDGE:      cfg_q.rising_edge_mode <= cfg_data[0];
				pet_pkg::CFG_GUARD_BEFORE:     cfg_q.guard_before_talk_us <= cfg_data;
				pet_pkg::CFG_GUARD_AFTER:      cfg_q.guard_after_beep_us <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/pet_core.sv
// ping state machine: one heartbeat step from state, config and the staged item
module pet_core #(
	parameter int NUM_BINS  = pet_pkg::NUM_BINS_DEF,
	parameter int TIME_BITS = pet_pkg::TIME_BITS_DEF,
	parameter int MAG_BITS  = pet_pkg::MAG_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  pet_pkg::item_t   item,
	input  pet_pkg::cfg_t    cfg,
	output pet_pkg::result_t res
);

	typedef struct packed {
		logic                             receiving;
		logic                             peak_search;
		logic                             continuous_tx;
		logic                             hv_latched_off;
		logic                             relay_rx;
		logic                             sampler_on;
		logic [TIME_BITS-1:0]             talk_start;
		logic [TIME_BITS-1:0]             listen_start;
		logic [TIME_BITS-1:0]             peak_time;
		logic [TIME_BITS-1:0]             peak_deadline;
		logic [TIME_BITS-1:0]             reply_deadline;
		logic [TIME_BITS-1:0]             cont_end;
		logic [MAG_BITS-1:0]              best_mag;
		logic [pet_pkg::BIN_IDX_BITS-1:0] tracked_bin;
		logic [pet_pkg::COUNT_BITS-1:0]   done_count;
		logic [pet_pkg::COUNT_BITS-1:0]   cmd_count;
	} core_state_t;

	core_state_t st_q;
	core_state_t st_d;

	logic [pet_pkg::MAG_FIELDS-1:0][pet_pkg::MAG_FIELD_BITS-1:0] fields;
	logic [MAG_BITS-1:0] mag [pet_pkg::BIN_SLOTS];

	assign fields = {item.mag_bin5, item.mag_bin4, item.mag_bin3,
		item.mag_bin2, item.mag_bin1, item.mag_bin0};

	// bins past the configured count or the input fields read as zero
	for (genvar g = 0; g < pet_pkg::BIN_SLOTS; g++) begin : g_mag
		if (g < NUM_BINS && g < pet_pkg::MAG_FIELDS) begin : g_live
			assign mag[g] = MAG_BITS'(fields[g]);
		end else begin : g_zero
			assign mag[g] = '0;
		end
	end

	always_comb begin
		logic [TIME_BITS-1:0]           now;
		logic [TIME_BITS-1:0]           thr_span;
		logic [31:0]                    cont_us;
		logic [MAG_BITS-1:0]            thr;
		logic [MAG_BITS-1:0]            tmag;
		logic [pet_pkg::COUNT_BITS-1:0] next_done;
		logic                           found;
		logic                           fin;
		logic                           fin_to;

		st_d     = st_q;
		res      = '0;
		now      = TIME_BITS'(item.now_us);
		cont_us  = item.cmd_arg * pet_pkg::MS_TO_US;
		thr      = MAG_BITS'(cfg.detect_threshold);
		tmag     = mag[st_q.tracked_bin];
		thr_span = '0;
		found    = 1'b0;
		fin      = 1'b0;
		fin_to   = 1'b0;
		next_done = '0;
		res.pings_done = st_q.done_count;

		if (item.leak_seen) begin
			st_d.hv_latched_off = 1'b1;
			st_d.relay_rx       = 1'b1;
			st_d.sampler_on     = 1'b0;
			res.leak_alarm      = 1'b1;
		end else begin
			unique case (item.func)
				pet_pkg::FUNC_GO: begin
					st_d.cmd_count      = item.cmd_arg[pet_pkg::COUNT_BITS-1:0];
					st_d.talk_start     = now;
					st_d.reply_deadline = now + TIME_BITS'(cfg.reply_timeout_us);
				end
				pet_pkg::FUNC_STOP: begin
					st_d.continuous_tx = 1'b0;
					st_d.relay_rx      = 1'b0;
					st_d.sampler_on    = 1'b0;
					st_d.done_count    = '0;
					st_d.cmd_count     = '0;
					st_d.receiving     = 1'b0;
					st_d.peak_search   = 1'b0;
				end
				pet_pkg::FUNC_CONTINUOUS: begin
					st_d.continuous_tx = 1'b1;
					st_d.cont_end      = now + TIME_BITS'(cont_us);
				end
				pet_pkg::FUNC_HEARTBEAT: begin
				end
			endcase
			res.pings_done = st_d.done_count;

			if (st_d.continuous_tx) begin
				if (now < st_d.cont_end)
					res.tx_on = 1'b1;
				else
					st_d.continuous_tx = 1'b0;
			end else if (st_d.done_count < st_d.cmd_count) begin
				if (!st_d.receiving) begin
					if (now >= st_d.talk_start) begin
						thr_span = now - st_d.talk_start;
						// compare wide so a short time width never clips the beep length
						if (64'(thr_span) < 64'(cfg.beep_length_us)) begin
							res.tx_on = 1'b1;
						end else begin
							st_d.listen_start = now + TIME_BITS'(cfg.guard_after_beep_us);
							st_d.receiving    = 1'b1;
							st_d.relay_rx     = 1'b1;
							st_d.sampler_on   = 1'b1;
						end
					end
				end else if (now >= st_d.reply_deadline) begin
					fin    = 1'b1;
					fin_to = 1'b1;
				end else if (now >= st_d.listen_start) begin
					if (st_d.peak_search) begin
						if (cfg.rising_edge_mode || now >= st_d.peak_deadline) begin
							fin = 1'b1;
						end else if (tmag > st_d.best_mag) begin
							st_d.best_mag  = tmag;
							st_d.peak_time = now;
						end
					end else begin
						// first bin over threshold wins
						for (int b = 0; b < NUM_BINS; b++) begin
							if (!found && mag[3'(b)] > thr) begin
								found              = 1'b1;
								st_d.best_mag      = mag[3'(b)];
								st_d.peak_time     = now;
								st_d.peak_deadline = now + TIME_BITS'(cfg.peak_window_us);
								st_d.tracked_bin   = 3'(b);
								st_d.peak_search   = 1'b1;
								res.detect_event   = 1'b1;
							end
						end
					end
				end
			end

			if (fin) begin
				res.trip_valid     = 1'b1;
				res.trip_timed_out = fin_to;
				res.trip_time_us   = fin_to ? '1 : 32'(st_d.peak_time - st_d.talk_start);
				st_d.best_mag    = '0;
				st_d.peak_search = 1'b0;
				st_d.receiving   = 1'b0;
				st_d.sampler_on  = 1'b0;
				st_d.relay_rx    = 1'b0;
				next_done        = st_d.done_count + 1'b1;
				res.pings_done   = next_done;
				if (next_done < st_d.cmd_count) begin
					st_d.done_count     = next_done;
					st_d.talk_start     = now + TIME_BITS'(cfg.guard_before_talk_us);
					st_d.reply_deadline = now + TIME_BITS'(cfg.guard_before_talk_us)
						+ TIME_BITS'(cfg.reply_timeout_us);
				end else begin
					res.series_done = 1'b1;
					st_d.cmd_count  = '0;
					st_d.done_count = '0;
				end
			end
		end

		res.relay_rx        = st_d.relay_rx;
		res.sampler_on      = st_d.sampler_on;
		res.high_voltage_on = !st_d.hv_latched_off;
		res.detected_bin    = st_d.tracked_bin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= st_d;
		end
	end

endmodule

// File: rtl/ping_echo_trip_timer.sv
// top level of the ping and echo round-trip timer: input stage, step core, result register
//
// channel   signals                                   direction
// item      item_valid, item_stall, item              in, one heartbeat per transfer
// result    result_valid, result_stall, result        out, one result per heartbeat
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in, register writes
//
// an item is registered on transfer, stepped through the ping state machine once the
// result slot is free, and its result lands in the result register. one heartbeat
// per cycle while results flow; the single state update per step sets that figure. reset
// clears the core state, config and valid flags; config writes are always taken.
// a stalled result holds the step stage, and item_stall rises only while both are full.
module ping_echo_trip_timer #(
	parameter int NUM_BINS  = pet_pkg::NUM_BINS_DEF,
	parameter int TIME_BITS = pet_pkg::TIME_BITS_DEF,
	parameter int MAG_BITS  = pet_pkg::MAG_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  pet_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output pet_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pet_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [pet_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	pet_pkg::cfg_t    cfg;
	pet_pkg::item_t   item_s1;
	logic             vld_s1;
	pet_pkg::result_t res;
	pet_pkg::result_t result_q;
	logic             result_vld_q;
	logic             adv;
	logic             step;
	logic             take;

	pet_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pet_core #(
		.NUM_BINS  (NUM_BINS),
		.TIME_BITS (TIME_BITS),
		.MAG_BITS  (MAG_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result slot frees when empty or when its transfer completes
	assign adv          = !result_vld_q || !result_stall;
	assign step         = vld_s1 && adv;
	assign item_stall   = vld_s1 && !adv;
	assign take         = item_valid && !item_stall;
	assign result_valid = result_vld_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (step) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_vld_q <= 1'b0;
		end else if (step) begin
			result_vld_q <= 1'b1;
		end else if (!result_stall) begin
			result_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			result_q <= res;
	end

endmodule

// File: dv/pet_trip_monitor.sv
// channel monitor, step predictor and result comparison for the ping and echo trip timer
module pet_trip_monitor
	import pet_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	input  logic                     item_stall,
	input  item_t                    item,
	input  logic                     result_valid,
	input  logic                     result_stall,
	input  result_t                  result,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output int                       mismatch_count,
	output int                       results_due
);

	cfg_t settings;

	logic        receiving, peak_search, cont_tx, hv_off, relay_rx, sampler_on;
	logic [31:0] talk_start, listen_start, peak_at, peak_deadline, reply_deadline, cont_end;
	logic [23:0] best_mag;
	logic [2:0]  tracked;
	logic [15:0] done_cnt, commanded_cnt;

	result_t step_results_due[$];
	result_t want;

	// closes the running ping and starts the next one of the series, if any
	function automatic result_t end_ping(input logic [31:0] now, input logic timed_out,
			input result_t r);
		r.trip_valid = 1'b1;
		r.trip_timed_out = timed_out;
		r.trip_time_us = timed_out ? 32'hFFFF_FFFF : peak_at - talk_start;
		best_mag = '0;
		peak_search = 1'b0;
		receiving = 1'b0;
		sampler_on = 1'b0;
		relay_rx = 1'b0;
		done_cnt = done_cnt + 16'd1;
		r.pings_done = done_cnt;
		if (done_cnt < commanded_cnt) begin
			talk_start = now + settings.guard_before_talk_us;
			reply_deadline = talk_start + settings.reply_timeout_us;
		end else begin
			r.series_done = 1'b1;
			commanded_cnt = '0;
			done_cnt = '0;
		end
		return r;
	endfunction

	function automatic result_t predict_heartbeat(input item_t it);
		result_t     r;
		logic [23:0] mags [8];
		logic [31:0] now;
		logic        found;
		now = it.now_us;
		mags[0] = it.mag_bin0;
		mags[1] = it.mag_bin1;
		mags[2] = it.mag_bin2;
		mags[3] = it.mag_bin3;
		mags[4] = it.mag_bin4;
		mags[5] = it.mag_bin5;
		mags[6] = '0;
		mags[7] = '0;
		r = '0;
		r.pings_done = done_cnt;
		if (it.leak_seen) begin
			// leak skips command and ping step alike
			hv_off = 1'b1;
			relay_rx = 1'b1;
			sampler_on = 1'b0;
			r.leak_alarm = 1'b1;
		end else begin
			case (it.func)
				FUNC_GO: begin
					commanded_cnt = it.cmd_arg[15:0];
					talk_start = now;
					reply_deadline = now + settings.reply_timeout_us;
				end
				FUNC_STOP: begin
					cont_tx = 1'b0;
					relay_rx = 1'b0;
					sampler_on = 1'b0;
					done_cnt = '0;
					commanded_cnt = '0;
					receiving = 1'b0;
					peak_search = 1'b0;
				end
				FUNC_CONTINUOUS: begin
					cont_tx = 1'b1;
					cont_end = now + it.cmd_arg * MS_TO_US;
				end
				default: ;
			endcase
			r.pings_done = done_cnt;
			if (cont_tx) begin
				if (now < cont_end)
					r.tx_on = 1'b1;
				else
					cont_tx = 1'b0;
			end else if (done_cnt < commanded_cnt) begin
				if (!receiving) begin
					if (now >= talk_start) begin
						if (now - talk_start < settings.beep_length_us) begin
							r.tx_on = 1'b1;
						end else begin
							listen_start = now + settings.guard_after_beep_us;
							receiving = 1'b1;
							relay_rx = 1'b1;
							sampler_on = 1'b1;
						end
					end
				end else if (now >= reply_deadline) begin
					r = end_ping(now, 1'b1, r);
				end else if (now >= listen_start) begin
					if (peak_search) begin
						if (settings.rising_edge_mode || now >= peak_deadline) begin
							r = end_ping(now, 1'b0, r);
						end else if (mags[tracked] > best_mag) begin
							best_mag = mags[tracked];
							peak_at = now;
						end
					end else begin
						found = 1'b0;
						// first bin over threshold wins
						for (int b = 0; b < NUM_BINS_DEF; b++) begin
							if (!found && mags[b] > settings.detect_threshold) begin
								found = 1'b1;
								best_mag = mags[b];
								peak_at = now;
								peak_deadline = now + settings.peak_window_us;
								tracked = 3'(b);
								peak_search = 1'b1;
								r.detect_event = 1'b1;
							end
						end
					end
				end
			end
		end
		r.relay_rx = relay_rx;
		r.sampler_on = sampler_on;
		r.high_voltage_on = !hv_off;
		r.detected_bin = tracked;
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, exp_val, act_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings = '0;
			{receiving, peak_search, cont_tx, hv_off, relay_rx, sampler_on} = '0;
			{talk_start, listen_start, peak_at, peak_deadline, reply_deadline, cont_end} = '0;
			best_mag = '0;
			tracked = '0;
			done_cnt = '0;
			commanded_cnt = '0;
			step_results_due.delete();
			mismatch_count = 0;
			results_due <= 0;
		end else begin
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				if (step_results_due.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with none pending, expected none actual %h",
						$time, result);
				end else begin
					want = step_results_due.pop_front();
					check_field("tx_on", 32'(want.tx_on), 32'(result.tx_on));
					check_field("relay_rx", 32'(want.relay_rx), 32'(result.relay_rx));
					check_field("sampler_on", 32'(want.sampler_on), 32'(result.sampler_on));
					check_field("high_voltage_on", 32'(want.high_voltage_on),
						32'(result.high_voltage_on));
					check_field("trip_valid", 32'(want.trip_valid), 32'(result.trip_valid));
					check_field("trip_timed_out", 32'(want.trip_timed_out),
						32'(result.trip_timed_out));
					check_field("trip_time_us", want.trip_time_us, result.trip_time_us);
					check_field("detected_bin", 32'(want.detected_bin), 32'(result.detected_bin));
					check_field("detect_event", 32'(want.detect_event), 32'(result.detect_event));
					check_field("series_done", 32'(want.series_done), 32'(result.series_done));
					check_field("pings_done", 32'(want.pings_done), 32'(result.pings_done));
					check_field("leak_alarm", 32'(want.leak_alarm), 32'(result.leak_alarm));
				end
			end
			if (item_valid === 1'b1 && item_stall === 1'b0)
				step_results_due.push_back(predict_heartbeat(item));
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
				case (cfg_index)
					CFG_DETECT_THRESHOLD: settings.detect_threshold = cfg_data[23:0];
					CFG_PEAK_WINDOW:      settings.peak_window_us = cfg_data;
					CFG_BEEP_LENGTH:      settings.beep_length_us = cfg_data;
					CFG_REPLY_TIMEOUT:    settings.reply_timeout_us = cfg_data;
					CFG_RISING_EDGE:      settings.rising_edge_mode = cfg_data[0];
					CFG_GUARD_BEFORE:     settings.guard_before_talk_us = cfg_data;
					CFG_GUARD_AFTER:      settings.guard_after_beep_us = cfg_data;
					default: ;
				endcase
			end
			results_due <= step_results_due.size();
		end
	end

endmodule

// File: dv/tb_ping_echo_trip_timer.sv
// stimulus, handshake pacing and verdict for the ping and echo trip timer
module tb_ping_echo_trip_timer;
	import pet_pkg::*;

	localparam int PHASE_BEATS = 330;
	localparam int PHASES      = 6;
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 300000;

	logic                     clk, arst_n;
	logic                     item_valid, item_stall;
	item_t                    item;
	logic                     result_valid, result_stall;
	result_t                  result;
	logic                     cfg_valid, cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	int          mismatches, results_due;
	int          send_idle_pct, recv_idle_pct, burst_left;
	int          cycle_count = 0;
	logic        hold_request;
	logic [31:0] clock_us;
	cfg_t        active;

	ping_echo_trip_timer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	pet_trip_monitor trip_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item           (item),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatches),
		.results_due    (results_due)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: random stalls, or one long hold-off on request
	initial begin
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic push_item(input item_t it);
		while ($urandom_range(99) < (burst_left > 0 ? 0 : send_idle_pct)) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall !== 1'b0);
	endtask

	task automatic beat(input logic [1:0] f, input logic [31:0] arg, input logic [31:0] t,
			input logic leak, input logic [143:0] mags);
		item_t it;
		it.func = f;
		it.cmd_arg = arg;
		it.now_us = t;
		it.leak_seen = leak;
		{it.mag_bin0, it.mag_bin1, it.mag_bin2, it.mag_bin3, it.mag_bin4, it.mag_bin5} = mags;
		push_item(it);
	endtask

	// mostly below threshold, now and then a reply above it or a fully random value
	function automatic logic [23:0] pick_mag();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 6)
			return 24'($urandom());
		if (roll < 12 && active.detect_threshold != 24'hFFFFFF)
			return 24'($urandom_range(24'hFFFFFF, active.detect_threshold + 1));
		return 24'($urandom_range(active.detect_threshold, 0));
	endfunction

	task automatic random_beat();
		int unsigned roll;
		logic [1:0]   f;
		logic [31:0]  arg;
		logic [143:0] mags;
		roll = $urandom_range(999);
		arg = $urandom_range(1) ? $urandom() : 32'd0;
		f = FUNC_HEARTBEAT;
		if (roll < 25) begin
			f = FUNC_GO;
			arg = $urandom_range(3) != 0 ? $urandom_range(5) : $urandom();
		end else if (roll < 35) begin
			f = FUNC_STOP;
		end else if (roll < 42) begin
			f = FUNC_CONTINUOUS;
			arg = $urandom_range(7) != 0 ? $urandom_range(2) : $urandom();
		end
		roll = $urandom_range(99);
		if (roll < 2)
			clock_us += $urandom_range(4000);
		else if (roll >= 10)
			clock_us += $urandom_range(40, 1);
		for (int b = 0; b < MAG_FIELDS; b++)
			mags = {mags[119:0], pick_mag()};
		beat(f, arg, clock_us, $urandom_range(199) == 0, mags);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
	endtask

	task automatic apply_settings(input cfg_t s);
		write_reg(CFG_DETECT_THRESHOLD, 32'(s.detect_threshold));
		write_reg(CFG_PEAK_WINDOW, s.peak_window_us);
		write_reg(CFG_BEEP_LENGTH, s.beep_length_us);
		write_reg(CFG_REPLY_TIMEOUT, s.reply_timeout_us);
		write_reg(CFG_RISING_EDGE, 32'(s.rising_edge_mode));
		write_reg(CFG_GUARD_BEFORE, s.guard_before_talk_us);
		write_reg(CFG_GUARD_AFTER, s.guard_after_beep_us);
		cfg_valid <= 1'b0;
		active = s;
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	function automatic cfg_t random_settings();
		cfg_t s;
		s.detect_threshold = $urandom_range(3) == 0 ? 24'($urandom()) : 24'($urandom_range(4000));
		s.peak_window_us = $urandom_range(300);
		s.beep_length_us = $urandom_range(150);
		s.reply_timeout_us = $urandom_range(7) == 0 ? $urandom_range(100) :
			$urandom_range(3000, 200);
		s.rising_edge_mode = 1'($urandom_range(1));
		s.guard_before_talk_us = $urandom_range(200);
		s.guard_after_beep_us = $urandom_range(100);
		return s;
	endfunction

	initial begin
		cfg_t s;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 38;
		recv_idle_pct = 51;
		hold_request = 1'b0;
		burst_left = 0;
		clock_us = '0;
		active = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero settings: every ping times out right after its beep
		apply_settings('0);
		beat(FUNC_HEARTBEAT, '0, '0, 1'b0, '0);
		beat(FUNC_HEARTBEAT, '1, '1, 1'b0, '1);
		beat(FUNC_GO, 32'd2, 32'd100, 1'b0, '0);
		beat(FUNC_HEARTBEAT, '0, 32'd110, 1'b0, {24'd0, 24'd0, 24'd5, 24'd0, 24'd0, 24'd0});
		beat(FUNC_HEARTBEAT, '0, 32'd120, 1'b0, '0);
		beat(FUNC_HEARTBEAT, '0, 32'd130, 1'b0, '0);
		beat(FUNC_CONTINUOUS, 32'd1, 32'd200, 1'b0, '0);
		beat(FUNC_HEARTBEAT, '0, 32'd700, 1'b0, '0);
		beat(FUNC_HEARTBEAT, '0, 32'd1300, 1'b0, '0);
		// the millisecond to microsecond product wraps in 32 bits
		beat(FUNC_CONTINUOUS, '1, 32'd5, 1'b0, '0);
		beat(FUNC_STOP, '0, 32'd10, 1'b0, '0);
		// go with zero in the low half does nothing
		beat(FUNC_GO, 32'h0001_0000, 32'd20, 1'b0, '0);
		beat(FUNC_GO, 32'd3, 32'd30, 1'b1, '1);
		wait_drained();

		// one full ping: beep, deaf time, detect on the first bin over threshold, peak
		s = '{detect_threshold: 24'd100, peak_window_us: 32'd50, beep_length_us: 32'd20,
			reply_timeout_us: 32'd1000, rising_edge_mode: 1'b0, guard_before_talk_us: 32'd10,
			guard_after_beep_us: 32'd5};
		apply_settings(s);
		beat(FUNC_GO, 32'd1, 32'd1000, 1'b0, '0);
		beat(FUNC_HEARTBEAT, '0, 32'd1010, 1'b0, '0);
		beat(FUNC_HEARTBEAT, '0, 32'd1020, 1'b0, '0);
		beat(FUNC_HEARTBEAT, '0, 32'd1022, 1'b0, {24'd0, 24'd0, 24'd0, 24'd200, 24'd0, 24'd0});
		beat(FUNC_HEARTBEAT, '0, 32'd1030, 1'b0, {24'd50, 24'd0, 24'd0, 24'd0, 24'd300, 24'd400});
		beat(FUNC_HEARTBEAT, '0, 32'd1040, 1'b0, {24'd0, 24'd0, 24'd0, 24'd0, 24'd500, 24'd0});
		beat(FUNC_HEARTBEAT, '0, 32'd1080, 1'b0, '0);
		wait_drained();

		apply_settings('1);
		beat(FUNC_GO, 32'h0000_FFFF, 32'h10, 1'b0, '0);
		beat(FUNC_HEARTBEAT, '0, 32'h20, 1'b0, '1);
		wait_drained();

		clock_us = 32'd2000;
		for (int phase = 0; phase < PHASES; phase++) begin
			send_idle_pct = phase < 2 ? 38 : phase < 4 ? 51 : 0;
			recv_idle_pct = phase < 2 ? 51 : phase < 4 ? 38 : 0;
			apply_settings(random_settings());
			// run the clock through the top of its range and wrap
			if (phase == 3)
				clock_us = 32'hFFFF_F000;
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (phase == 1 && n == 100) begin
					hold_request = 1'b1;
					burst_left = 30;
				end
				random_beat();
				if (burst_left > 0)
					burst_left--;
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
